FILE: rtl/core/dq_pkg.sv
package dq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  // request type codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   en;
    dq_op_t op;
  } dq_cmd_t;

endpackage

FILE: rtl/core/dq_cell.sv
module dq_cell import dq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dq_cmd_t               cmd,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] tail_word
);

  logic is_tail;
  logic is_slot;

  // this cell holds the back word, or is the first free place
  assign is_tail = valid && !right_valid;
  assign is_slot = !valid && left_valid;

  // back word offered to the pop-back read, zero elsewhere
  assign tail_word = is_tail ? data : '0;

  // occupancy, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en) begin
      unique case (cmd.op)
        OP_PUSH_FRONT: valid <= left_valid;
        OP_PUSH_BACK:  valid <= valid | is_slot;
        OP_POP_FRONT:  valid <= right_valid;
        OP_POP_BACK:   valid <= valid & !is_tail;
        default:       valid <= valid;
      endcase
    end
  end

  // payload moves with the shifts, no reset
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      unique case (cmd.op)
        OP_PUSH_FRONT: data <= left_data;
        OP_PUSH_BACK:  if (is_slot) data <= word;
        OP_POP_FRONT:  data <= right_data;
        default:       data <= data;
      endcase
    end
  end

endmodule

FILE: rtl/core/double_ended_queue.sv
// Double-ended queue of data words.
// Request channel: start with req_type and data_in; a request is taken at a
// rising edge where start is high and busy is low. busy is high only while
// rst is high, so a request can be issued in every cycle after reset.
// req_type: push front, push back, pop front, pop back.
// Result channel: done is high for exactly one cycle, the cycle after the
// request was taken, with data_out, status and count_after. Throughput is
// one request per cycle: every operation is a single
// shift or write across the row of cells plus the tail read.
// The words sit in a row of DEPTH cells, front word in cell 0. A push at the
// front shifts the row toward the back, a pop at the front shifts it toward
// the front; the back end is found locally by each cell from its own and its
// neighbor's occupancy bit.
// A push on a full queue is dropped with status full; a pop on an empty
// queue returns zero with status empty. Pushes return zero data.
// Reset (rst, synchronous) empties the queue and clears done.
// The receiver cannot stall: each result must be taken when done is high.
module double_ended_queue import dq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [31:0]        data_in,
  output logic               done,
  output logic [31:0]        data_out,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count_after
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  logic                  accept;
  dq_op_t                op;
  logic [DATA_WIDTH-1:0] word;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic                  full;
  logic                  empty;
  logic                  is_push;
  dq_status_t            st_next;
  dq_cmd_t               cmd;
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail  [DEPTH];
  logic [DATA_WIDTH-1:0] tail_any;
  logic [DATA_WIDTH-1:0] pop_word;

  assign busy   = rst;
  assign accept = start && !busy;
  assign op     = dq_op_t'(req_type);
  assign word   = DATA_WIDTH'(data_in);

  // request decode
  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);

  always_comb begin
    st_next    = ST_OK;
    count_next = count;
    if (is_push) begin
      if (full) st_next = ST_FULL;
      else count_next = count + 1'b1;
    end else begin
      if (empty) st_next = ST_EMPTY;
      else count_next = count - 1'b1;
    end
  end

  assign cmd.en = accept && (st_next == ST_OK);
  assign cmd.op = op;

  // row of cells, cell 0 holds the front word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] ld;
    logic                  lv;
    logic [DATA_WIDTH-1:0] rd;
    logic                  rv;

    if (i == 0) begin : g_first
      assign ld = word;
      assign lv = 1'b1;
    end else begin : g_mid
      assign ld = cell_data[i-1];
      assign lv = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rd = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rd = cell_data[i+1];
      assign rv = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .word        (word),
      .left_data   (ld),
      .left_valid  (lv),
      .right_data  (rd),
      .right_valid (rv),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail_word   (cell_tail[i])
    );
  end

  // at most one cell is the tail, so an or gathers the back word
  always_comb begin
    tail_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_any = tail_any | cell_tail[i];
    end
  end

  // popped word selection
  always_comb begin
    pop_word = '0;
    if (st_next == ST_OK) begin
      case (op)
        OP_POP_FRONT: pop_word = cell_data[0];
        OP_POP_BACK:  pop_word = tail_any;
        default:      pop_word = '0;
      endcase
    end
  end

  // count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out    <= 32'(pop_word);
      status      <= st_next;
      count_after <= count_next;
    end
  end

  // occupancy bits
  logic [DEPTH-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = cell_valid[i];
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("count differs from occupied cells");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("count above depth");

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> done && (count_after == count))
    else $error("result missing or count out of step");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> count_after == FULL_COUNT)
    else $error("full status with room left");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> count_after == '0 && data_out == '0)
    else $error("empty status with data");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import dq_pkg::*;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int CALM_TAIL       = 300;

  // deque predictor and result checker
  class deque_scoreboard;
    typedef struct {
      logic [DATA_WIDTH-1:0] word;
      dq_status_t            st;
      logic [COUNT_W-1:0]    cnt;
    } deque_result_t;

    logic [DATA_WIDTH-1:0] ring [DEPTH];
    int unsigned           head;
    int unsigned           count;
    deque_result_t         awaited [$];
    int unsigned           errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    // apply one accepted request to the shadow ring and queue its result
    function void note_request(dq_op_t op, logic [31:0] word);
      deque_result_t r;
      int unsigned   slot;
      r.word = '0;
      r.st   = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count >= DEPTH) begin
            r.st = ST_FULL;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slot = head;
            end else begin
              slot = (head + count) % DEPTH;
            end
            ring[slot] = DATA_WIDTH'(word);
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            r.st = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT) begin
              slot = head;
              head = (head + 1) % DEPTH;
            end else begin
              slot = (head + count - 1) % DEPTH;
            end
            r.word = ring[slot];
            count--;
          end
        end
      endcase
      r.cnt = count[COUNT_W-1:0];
      awaited.insert(awaited.size(), r);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(logic [31:0] d, logic [1:0] s, logic [COUNT_W-1:0] c);
      deque_result_t r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no request pending: data %h status %0d count %0d",
                   $realtime, d, s, c);
      end else begin
        r = awaited[0];
        awaited.delete(0);
        if (d !== r.word || s !== r.st || c !== r.cnt) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch: data %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, r.word, d, r.st, s, r.cnt, c);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = OP_PUSH_BACK;
  logic [31:0]        data_in = '0;
  logic               done;
  logic [31:0]        data_out;
  logic [1:0]         status;
  logic [COUNT_W-1:0] count_after;

  deque_scoreboard sb;

  double_ended_queue DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .data_in    (data_in),
    .done       (done),
    .data_out   (data_out),
    .status     (status),
    .count_after(count_after)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // issue one request and wait until it is taken
  task send_request(input dq_op_t op, input logic [31:0] word);
    start    <= 1'b1;
    req_type <= op;
    data_in  <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, word);
  endtask

  // sender gap with noise on the request fields
  task hold_idle(input int unsigned n);
    start    <= 1'b0;
    req_type <= dq_op_t'($urandom_range(0, 3));
    data_in  <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // check each result in the cycle it is presented
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(data_out, status, count_after);
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned push_pct;
    bit          gaps;
    dq_op_t      op;
    logic [31:0] word;

    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // pops on empty, word extremes, then fill past full
    send_request(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_request(OP_POP_BACK, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h0000_0000);
    send_request(OP_POP_BACK, 32'hFFFF_FFFF);
    send_request(OP_POP_FRONT, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++)
      send_request(i % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT, (32'h1 << (2 * i)) ^ 32'hA5A5_5A5A);
    send_request(OP_PUSH_FRONT, 32'h1234_5678);
    send_request(OP_PUSH_BACK, 32'h8765_4321);

    // random runs biased toward filling, draining or mixing
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(8, 40);
      gaps    = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < run_len && sent < RANDOM_REQUESTS; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        case ($urandom_range(0, 15))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        if (gaps && sent < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
          hold_idle($urandom_range(1, 11));
        send_request(op, word);
        sent++;
      end
    end
    start <= 1'b0;

    // drain outstanding results
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: double_ended_queue.f
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
tb/tb.sv
